/* rtl/shared_memory_link_slave_defines.svh */
// Assertion macros shared by the checker of the shared-memory link slave.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef SHARED_MEMORY_LINK_SLAVE_DEFINES_SVH
`define SHARED_MEMORY_LINK_SLAVE_DEFINES_SVH

// Antecedent holds in a cycle, so the consequent must hold in that same cycle.
`define SMLS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds in a cycle, so the consequent must hold in the next one.
`define SMLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/smls_pkg.sv */
// Package for the shared-memory link slave: sizes, command, packet type
// and reply codes, and the controller-to-datapath command struct.
// Depends on nothing.
package smls_pkg;

    localparam int SMLS_MEM_WORDS = 262144;

    localparam int WORD_W  = 36;
    localparam int LIMIT_W = 19;
    // Wide enough for a 24-bit address and a limit of up to 2**24.
    localparam int CMP_W   = 25;

    localparam logic [3:0] PKT_MAX_LEN = 4'd9;

    localparam logic [2:0] CMD_PACKET     = 3'd0;
    localparam logic [2:0] CMD_CONNECT    = 3'd1;
    localparam logic [2:0] CMD_DROP       = 3'd2;
    localparam logic [2:0] CMD_CPU_CTRL   = 3'd3;
    localparam logic [2:0] CMD_CPU_STATUS = 3'd4;
    localparam logic [2:0] CMD_CPU_RDATA  = 3'd5;
    localparam logic [2:0] CMD_CPU_WDATA  = 3'd6;

    localparam logic [7:0] TYPE_WRITE = 8'd1;
    localparam logic [7:0] TYPE_READ  = 8'd2;
    localparam logic [7:0] TYPE_ACK   = 8'd3;
    localparam logic [7:0] TYPE_IRQ   = 8'd6;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_ERR    = 2'd2;
    localparam logic [1:0] KIND_CLOSED = 2'd3;

    localparam logic [2:0] LEN_NONE     = 3'd0;
    localparam logic [2:0] LEN_SHORT    = 3'd1;
    localparam logic [2:0] LEN_READ_ACK = 3'd6;

    typedef struct packed {
        logic accept;
        logic load_out;
    } smls_cmd_t;

endpackage

/* rtl/shared_memory_link_slave.sv */
// Shared-memory link slave: top level joining the controller and datapath.
// Depends on smls_pkg, smls_ctrl and smls_dp.
//
// Usage: one input channel (in_valid/in_stall) carries link packets, link
// connect and drop events and local CPU accesses; one output channel
// (out_valid/out_stall) returns exactly one result per input transfer, in
// order. A transfer happens when valid is high and stall is low.
// The memory limit register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high, and writes belong to idle periods only.
// An item is decoded and drives the single memory port as it is taken; its
// result waits in the staging registers until, in execution, it is loaded
// with the registered read data into the output register, raising out_valid.
// A finished result can wait in the output register while the next item is
// taken; a second item then stays in execution until the output drains, and
// in_stall stays high meanwhile.
// Reset closes the link, clears the interrupt flag and level and sets the
// limit to the memory size; memory contents are undefined until written.
module shared_memory_link_slave
    import smls_pkg::*;
#(
    parameter int MEM_WORDS = SMLS_MEM_WORDS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [3:0]         packet_length,
    input  logic [7:0]         packet_type,
    input  logic [23:0]        word_address,
    input  logic [39:0]        write_word,
    input  logic [WORD_W-1:0]  cpu_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         reply_kind,
    output logic [2:0]         reply_length,
    output logic [WORD_W-1:0]  read_word,
    output logic [3:0]         cpu_read_data,
    output logic               interrupt_active,
    output logic [2:0]         interrupt_level,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    smls_cmd_t cmd;

    assign cfg_ready = 1'b1;

    smls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    smls_dp #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .command          (command),
        .packet_length    (packet_length),
        .packet_type      (packet_type),
        .word_address     (word_address),
        .write_word       (write_word),
        .cpu_data         (cpu_data),
        .reply_kind       (reply_kind),
        .reply_length     (reply_length),
        .read_word        (read_word),
        .cpu_read_data    (cpu_read_data),
        .interrupt_active (interrupt_active),
        .interrupt_level  (interrupt_level)
    );

endmodule

/* rtl/smls_ram.sv */
// Generic single-port RAM with a registered read port.
// Depends on nothing.
module smls_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/smls_ctrl.sv */
// Controller of the shared-memory link slave: input and output handshakes
// and the command strobes to the datapath. Depends on smls_pkg.
module smls_ctrl
    import smls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output smls_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        cmd.accept   = in_valid && (state_reg == ST_IDLE);
        // The output register can be loaded when empty or emptied this cycle.
        cmd.load_out = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/smls_dp.sv */
// Datapath of the shared-memory link slave: item decode, link and interrupt
// state, memory limit, shared memory and result registers.
// Depends on smls_pkg and smls_ram.
module smls_dp
    import smls_pkg::*;
#(
    parameter int MEM_WORDS = SMLS_MEM_WORDS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  smls_cmd_t          cmd,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic [2:0]         command,
    input  logic [3:0]         packet_length,
    input  logic [7:0]         packet_type,
    input  logic [23:0]        word_address,
    input  logic [39:0]        write_word,
    input  logic [WORD_W-1:0]  cpu_data,
    output logic [1:0]         reply_kind,
    output logic [2:0]         reply_length,
    output logic [WORD_W-1:0]  read_word,
    output logic [3:0]         cpu_read_data,
    output logic               interrupt_active,
    output logic [2:0]         interrupt_level
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [CMP_W-1:0] MEM_LIMIT = CMP_W'(MEM_WORDS);

    logic [CMP_W-1:0] limit_reg;
    logic [2:0]       level_reg;
    logic [2:0]       level_next;
    logic             flag_reg;
    logic             flag_next;
    logic             link_reg;
    logic             link_next;

    // Result of the item in flight, waiting for the memory read data.
    logic [1:0] st_kind_reg;
    logic [1:0] st_kind_next;
    logic [2:0] st_len_reg;
    logic [2:0] st_len_next;
    logic       st_rd_reg;
    logic       st_rd_next;
    logic [3:0] st_cpu_reg;
    logic [3:0] st_cpu_next;

    logic [1:0]        kind_reg;
    logic [2:0]        len_reg;
    logic [WORD_W-1:0] word_reg;
    logic [3:0]        cpu_reg;
    logic              irq_reg;
    logic [2:0]        lvl_reg;

    logic [CMP_W-1:0]  limit_eff;
    logic              addr_ok;
    logic              ram_en;
    logic              ram_we;
    logic [WORD_W-1:0] ram_rdata;

    assign limit_eff = (limit_reg < MEM_LIMIT) ? limit_reg : MEM_LIMIT;
    assign addr_ok   = {1'b0, word_address} < limit_eff;

    always_comb
    begin
        level_next   = level_reg;
        flag_next    = flag_reg;
        link_next    = link_reg;
        st_kind_next = KIND_NONE;
        st_len_next  = LEN_NONE;
        st_rd_next   = 1'b0;
        st_cpu_next  = 4'd0;
        ram_en       = 1'b0;
        ram_we       = 1'b0;

        unique case (command)
            CMD_PACKET:
            begin
                if (link_reg && (packet_length != 4'd0))
                begin
                    if (packet_length > PKT_MAX_LEN)
                    begin
                        link_next    = 1'b0;
                        st_kind_next = KIND_CLOSED;
                    end
                    else
                    begin
                        unique case (packet_type)
                            TYPE_READ:
                            begin
                                if (addr_ok)
                                begin
                                    ram_en       = 1'b1;
                                    st_rd_next   = 1'b1;
                                    st_kind_next = KIND_ACK;
                                    st_len_next  = LEN_READ_ACK;
                                end
                                else
                                begin
                                    st_kind_next = KIND_ERR;
                                    st_len_next  = LEN_SHORT;
                                end
                            end
                            TYPE_WRITE:
                            begin
                                if (addr_ok)
                                begin
                                    ram_en       = 1'b1;
                                    ram_we       = 1'b1;
                                    st_kind_next = KIND_ACK;
                                end
                                else
                                begin
                                    st_kind_next = KIND_ERR;
                                end
                                st_len_next = LEN_SHORT;
                            end
                            TYPE_ACK:
                            begin
                                st_kind_next = KIND_NONE;
                            end
                            TYPE_IRQ:
                            begin
                                flag_next    = 1'b1;
                                st_kind_next = KIND_ACK;
                                st_len_next  = LEN_SHORT;
                            end
                            default:
                            begin
                                link_next    = 1'b0;
                                st_kind_next = KIND_CLOSED;
                            end
                        endcase
                    end
                end
            end
            CMD_CONNECT:
            begin
                link_next = 1'b1;
            end
            CMD_DROP:
            begin
                link_next = 1'b0;
            end
            CMD_CPU_CTRL:
            begin
                level_next = cpu_data[2:0];
                if (cpu_data[3])
                begin
                    flag_next = 1'b0;
                end
            end
            CMD_CPU_STATUS:
            begin
                st_cpu_next = {flag_reg, level_reg};
            end
            default:
            begin
                // CPU data reads answer zero; data writes and spare codes do nothing.
                st_cpu_next = 4'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= MEM_LIMIT;
            level_reg <= 3'd0;
            flag_reg  <= 1'b0;
            link_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= CMP_W'(cfg_data);
            end
            if (cmd.accept)
            begin
                level_reg <= level_next;
                flag_reg  <= flag_next;
                link_reg  <= link_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            st_kind_reg <= st_kind_next;
            st_len_reg  <= st_len_next;
            st_rd_reg   <= st_rd_next;
            st_cpu_reg  <= st_cpu_next;
        end
        if (cmd.load_out)
        begin
            kind_reg <= st_kind_reg;
            len_reg  <= st_len_reg;
            word_reg <= st_rd_reg ? ram_rdata : '0;
            cpu_reg  <= st_cpu_reg;
            irq_reg  <= flag_reg;
            lvl_reg  <= level_reg;
        end
    end

    smls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .en    (cmd.accept && ram_en),
        .we    (ram_we),
        .addr  (word_address[AW-1:0]),
        .wdata (write_word[WORD_W-1:0]),
        .rdata (ram_rdata)
    );

    assign reply_kind       = kind_reg;
    assign reply_length     = len_reg;
    assign read_word        = word_reg;
    assign cpu_read_data    = cpu_reg;
    assign interrupt_active = irq_reg;
    assign interrupt_level  = lvl_reg;

endmodule

/* rtl/smls_checker.sv */
// Port-level checker for the shared-memory link slave, bound to the top level.
// Depends on smls_pkg and shared_memory_link_slave_defines.svh.
`include "shared_memory_link_slave_defines.svh"

module smls_checker
    import smls_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         reply_kind,
    input logic [2:0]         reply_length,
    input logic [WORD_W-1:0]  read_word,
    input logic [3:0]         cpu_read_data,
    input logic               interrupt_active,
    input logic [2:0]         interrupt_level
);

    // A held result must stay offered until it is taken.
    `SMLS_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "result dropped while stalled")

    // Each input transfer is followed by in_stall high in the next cycle.
    `SMLS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken twice in a row")

    // Only ACK and ERR replies carry bytes.
    `SMLS_ASSERT_SAME(a_len_kind, out_valid && (reply_length != LEN_NONE), reply_kind == KIND_ACK || reply_kind == KIND_ERR, "reply length without a reply")

    // A returned word comes only with a read ACK.
    `SMLS_ASSERT_SAME(a_word_read, out_valid && (read_word != '0), reply_kind == KIND_ACK && reply_length == LEN_READ_ACK, "read word outside read ACK")

    // A status value reflects the interrupt state shown with it.
    `SMLS_ASSERT_SAME(a_status, out_valid && (cpu_read_data != 4'd0), cpu_read_data[2:0] == interrupt_level && cpu_read_data[3] == interrupt_active, "status disagrees with interrupt state")

endmodule

bind shared_memory_link_slave smls_checker u_smls_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for the shared-memory link slave: a queue-fed driver,
// a monitor with an in-order reply predictor, and randomised stalls on both sides.
// Depends on smls_pkg and the shared_memory_link_slave RTL.
module testbench;
    import smls_pkg::*;

    localparam logic [2:0] CMD_UNDEFINED = 3'd7;
    localparam int         SQUEEZE_CYCLES = 300;
    localparam int         PHASE_ITEMS    = 305;

    typedef struct packed {
        logic [2:0]        command;
        logic [3:0]        plen;
        logic [7:0]        ptype;
        logic [23:0]       addr;
        logic [39:0]       wdata;
        logic [WORD_W-1:0] cdata;
    } link_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        rlen;
        logic [WORD_W-1:0] rword;
        logic [3:0]        status;
        logic              irq;
        logic [2:0]        level;
    } reply_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         command = CMD_CONNECT;
    logic [3:0]         packet_length = '0;
    logic [7:0]         packet_type = '0;
    logic [23:0]        word_address = '0;
    logic [39:0]        write_word = '0;
    logic [WORD_W-1:0]  cpu_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         reply_kind;
    logic [2:0]         reply_length;
    logic [WORD_W-1:0]  read_word;
    logic [3:0]         cpu_read_data;
    logic               interrupt_active;
    logic [2:0]         interrupt_level;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;

    // Predictor copy of the block state.
    bit [WORD_W-1:0]    mem_image [int unsigned];
    logic               link_up = 1'b0;
    logic               irq_flag = 1'b0;
    logic [2:0]         irq_level = 3'd0;
    logic [LIMIT_W-1:0] limit_copy = LIMIT_W'(SMLS_MEM_WORDS);

    // Planning state used while generating stimulus, so that no read reaches
    // a word that has never been written.
    logic               plan_link = 1'b0;
    int unsigned        plan_limit = SMLS_MEM_WORDS;
    int unsigned        written_list [$];
    bit                 written_mark [int unsigned];

    link_item_t         pending_items [$];
    reply_t             replies_due [$];
    link_item_t         drive_item;
    link_item_t         seen_item;
    reply_t             due;

    int                 queued_count = 0;
    int                 sent_count = 0;
    int                 taken_count = 0;
    int                 fail_count = 0;
    int                 gap_left = 0;
    int                 burst_left = 0;
    int                 stall_mode = 0;
    int                 mode_left = 0;
    int                 squeeze_asked = 0;
    int                 squeeze_done = 0;
    int                 squeeze_cycles = 0;
    int                 kind_tally [4] = '{0, 0, 0, 0};
    int                 read_acks = 0;
    int                 status_reads = 0;
    int                 limit_settings = 0;

    shared_memory_link_slave u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .packet_length    (packet_length),
        .packet_type      (packet_type),
        .word_address     (word_address),
        .write_word       (write_word),
        .cpu_data         (cpu_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .reply_kind       (reply_kind),
        .reply_length     (reply_length),
        .read_word        (read_word),
        .cpu_read_data    (cpu_read_data),
        .interrupt_active (interrupt_active),
        .interrupt_level  (interrupt_level),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic reply_t predict_reply(input link_item_t it);
        reply_t      r;
        int unsigned lim;
        r = '0;
        lim = (limit_copy > SMLS_MEM_WORDS) ? SMLS_MEM_WORDS : limit_copy;
        case (it.command)
            CMD_PACKET:
            begin
                if (link_up && it.plen != 4'd0)
                begin
                    if (it.plen > PKT_MAX_LEN)
                    begin
                        link_up = 1'b0;
                        r.kind = KIND_CLOSED;
                    end
                    else
                    begin
                        case (it.ptype)
                            TYPE_READ:
                            begin
                                if (it.addr < lim)
                                begin
                                    r.rword = mem_image.exists(it.addr) ? mem_image[it.addr] : '0;
                                    r.kind = KIND_ACK;
                                    r.rlen = LEN_READ_ACK;
                                end
                                else
                                begin
                                    r.kind = KIND_ERR;
                                    r.rlen = LEN_SHORT;
                                end
                            end
                            TYPE_WRITE:
                            begin
                                if (it.addr < lim)
                                begin
                                    // The top four bits of the link data never reach memory.
                                    mem_image[it.addr] = it.wdata[WORD_W-1:0];
                                    r.kind = KIND_ACK;
                                end
                                else
                                    r.kind = KIND_ERR;
                                r.rlen = LEN_SHORT;
                            end
                            TYPE_ACK:
                                ;
                            TYPE_IRQ:
                            begin
                                irq_flag = 1'b1;
                                r.kind = KIND_ACK;
                                r.rlen = LEN_SHORT;
                            end
                            default:
                            begin
                                link_up = 1'b0;
                                r.kind = KIND_CLOSED;
                            end
                        endcase
                    end
                end
            end
            CMD_CONNECT:
                link_up = 1'b1;
            CMD_DROP:
                link_up = 1'b0;
            CMD_CPU_CTRL:
            begin
                irq_level = it.cdata[2:0];
                if (it.cdata[3])
                    irq_flag = 1'b0;
            end
            CMD_CPU_STATUS:
                r.status = {irq_flag, irq_level};
            default:
                ;
        endcase
        r.irq = irq_flag;
        r.level = irq_level;
        return r;
    endfunction

    // Tracks link state and successful writes as the items will see them.
    function automatic void queue_item(input link_item_t it);
        if (it.command == CMD_PACKET && plan_link && it.plen != 4'd0)
        begin
            if (it.plen > PKT_MAX_LEN)
                plan_link = 1'b0;
            else if (it.ptype == TYPE_WRITE)
            begin
                if (it.addr < plan_limit && !written_mark.exists(it.addr))
                begin
                    written_mark[it.addr] = 1'b1;
                    written_list.push_back(32'(it.addr));
                end
            end
            else if (!(it.ptype inside {TYPE_READ, TYPE_ACK, TYPE_IRQ}))
                plan_link = 1'b0;
        end
        else if (it.command == CMD_CONNECT)
            plan_link = 1'b1;
        else if (it.command == CMD_DROP)
            plan_link = 1'b0;
        pending_items.push_back(it);
        queued_count++;
    endfunction

    function automatic link_item_t make_item(input logic [2:0] cmd, input logic [3:0] plen,
                                             input logic [7:0] ptype, input logic [23:0] addr,
                                             input logic [39:0] wdata,
                                             input logic [WORD_W-1:0] cdata);
        link_item_t it;
        it.command = cmd;
        it.plen = plen;
        it.ptype = ptype;
        it.addr = addr;
        it.wdata = wdata;
        it.cdata = cdata;
        return it;
    endfunction

    function automatic link_item_t random_item();
        link_item_t  it;
        logic [63:0] bits;
        int unsigned pick;
        int unsigned coin;
        int unsigned span;
        bits = {$urandom(), $urandom()};
        it.wdata = bits[39:0];
        bits = {$urandom(), $urandom()};
        it.cdata = bits[WORD_W-1:0];
        it.command = CMD_PACKET;
        it.plen = 4'($urandom_range(1, PKT_MAX_LEN));
        it.ptype = 8'($urandom_range(0, 255));
        it.addr = 24'($urandom_range(0, 24'hFFFFFF));
        pick = $urandom_range(0, 99);
        coin = $urandom_range(0, 99);
        if (!plan_link && pick < 70)
            it.command = CMD_CONNECT;
        else if (pick < 60)
            it.ptype = (coin < 40) ? TYPE_WRITE : (coin < 75) ? TYPE_READ :
                       (coin < 85) ? TYPE_IRQ : TYPE_ACK;
        else if (pick < 72)
            it.command = 3'($urandom_range(CMD_CPU_CTRL, CMD_CPU_WDATA));
        else if (pick < 76)
            it.command = CMD_CONNECT;
        else if (pick < 79)
            it.command = CMD_DROP;
        else if (pick < 83)
            it.plen = 4'd0;
        else if (pick < 87)
            it.plen = 4'($urandom_range(PKT_MAX_LEN + 1, 15));
        else if (pick < 91)
        begin
            while (it.ptype inside {TYPE_WRITE, TYPE_READ, TYPE_ACK, TYPE_IRQ})
                it.ptype = 8'($urandom_range(0, 255));
        end
        else if (pick < 94)
            it.command = CMD_UNDEFINED;
        else
        begin
            it.command = 3'($urandom_range(0, 7));
            it.plen = 4'($urandom_range(0, 15));
        end

        coin = $urandom_range(0, 99);
        if (it.ptype == TYPE_READ)
        begin
            if (written_list.size() != 0 && coin < 80)
                it.addr = 24'(written_list[$urandom_range(0, written_list.size() - 1)]);
            else
                it.addr = 24'($urandom_range(plan_limit, 24'hFFFFFF));
        end
        else if (it.ptype == TYPE_WRITE && plan_limit != 0 && coin < 80)
        begin
            // Half of the in-range writes land in a small window so that words get rewritten.
            span = (coin < 40 && plan_limit > 64) ? 64 : plan_limit;
            it.addr = 24'($urandom_range(0, span - 1));
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        limit_copy = value;
        plan_limit = (value > SMLS_MEM_WORDS) ? SMLS_MEM_WORDS : value;
        limit_settings++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (pending_items.size() != 0 || taken_count != queued_count)
            @(posedge clk);
        while (replies_due.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        if (replies_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", replies_due.size()));
            replies_due.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // Sender: offers queued items in bursts, holding each one until its transfer.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || taken_count == sent_count))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                drive_item = pending_items.pop_front();
                command <= drive_item.command;
                packet_length <= drive_item.plen;
                packet_type <= drive_item.ptype;
                word_address <= drive_item.addr;
                write_word <= drive_item.wdata;
                cpu_data <= drive_item.cdata;
                in_valid <= 1'b1;
                sent_count++;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall pattern of its own, with a long hold-off on request.
    always @(negedge clk)
    begin
        if (squeeze_asked != squeeze_done)
        begin
            out_stall <= 1'b1;
            squeeze_cycles++;
            if (squeeze_cycles == SQUEEZE_CYCLES)
            begin
                squeeze_cycles = 0;
                squeeze_done++;
            end
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen_item = make_item(command, packet_length, packet_type, word_address,
                                      write_word, cpu_data);
                if (command == CMD_CPU_STATUS)
                    status_reads++;
                replies_due.push_back(predict_reply(seen_item));
                taken_count++;
            end
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                    report_mismatch($sformatf("result with nothing expected, kind %0d",
                                              reply_kind));
                else
                begin
                    due = replies_due.pop_front();
                    check_field("reply_kind", reply_kind, due.kind);
                    check_field("reply_length", reply_length, due.rlen);
                    check_field("read_word", read_word, due.rword);
                    check_field("cpu_read_data", cpu_read_data, due.status);
                    check_field("interrupt_active", interrupt_active, due.irq);
                    check_field("interrupt_level", interrupt_level, due.level);
                    kind_tally[due.kind]++;
                    if (due.rlen == LEN_READ_ACK)
                        read_acks++;
                end
            end
        end
    end

    initial
    begin
        logic [LIMIT_W-1:0] limits [6];
        limits = '{19'h7FFFF, 19'd0, 19'd1, 19'd777, 19'd131072, LIMIT_W'(SMLS_MEM_WORDS)};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset limit and the link closed at first.
        queue_item(make_item(CMD_PACKET, 4'd9, TYPE_READ, 24'd0, '0, '0));
        queue_item(make_item(CMD_DROP, 4'd0, 8'd0, 24'd0, '0, '0));
        queue_item(make_item(CMD_CONNECT, 4'd0, 8'd0, 24'd0, '0, '0));
        queue_item(make_item(CMD_CONNECT, 4'd15, 8'hFF, 24'hFFFFFF, '1, '1));
        queue_item(make_item(CMD_PACKET, 4'd9, TYPE_WRITE, 24'd0, 40'hFF_FFFF_FFFF, '0));
        queue_item(make_item(CMD_PACKET, 4'd4, TYPE_READ, 24'd0, '0, '0));
        queue_item(make_item(CMD_PACKET, 4'd1, TYPE_WRITE, 24'(SMLS_MEM_WORDS - 1), '0, '0));
        queue_item(make_item(CMD_PACKET, 4'd9, TYPE_READ, 24'(SMLS_MEM_WORDS - 1), '0, '0));
        queue_item(make_item(CMD_PACKET, 4'd9, TYPE_READ, 24'hFFFFFF, '0, '0));
        queue_item(make_item(CMD_PACKET, 4'd9, TYPE_WRITE, 24'(SMLS_MEM_WORDS), '1, '0));
        queue_item(make_item(CMD_PACKET, 4'd0, TYPE_WRITE, 24'd5, '1, '0));
        queue_item(make_item(CMD_PACKET, 4'd1, TYPE_ACK, 24'd0, '0, '0));
        queue_item(make_item(CMD_PACKET, 4'd2, TYPE_IRQ, 24'd0, '0, '0));
        queue_item(make_item(CMD_CPU_STATUS, 4'd0, 8'd0, 24'd0, '0, '0));
        queue_item(make_item(CMD_CPU_CTRL, 4'd0, 8'd0, 24'd0, '0, 36'hFFFFFFFF7));
        queue_item(make_item(CMD_CPU_STATUS, 4'd0, 8'd0, 24'd0, '0, '0));
        queue_item(make_item(CMD_CPU_CTRL, 4'd0, 8'd0, 24'd0, '0, 36'hD));
        queue_item(make_item(CMD_CPU_RDATA, 4'd0, 8'd0, 24'd0, '0, '1));
        queue_item(make_item(CMD_CPU_WDATA, 4'd0, 8'd0, 24'd0, '0, '1));
        queue_item(make_item(CMD_UNDEFINED, 4'd9, TYPE_IRQ, 24'd0, '0, '1));
        queue_item(make_item(CMD_PACKET, 4'd10, TYPE_READ, 24'd0, '0, '0));
        queue_item(make_item(CMD_PACKET, 4'd9, TYPE_WRITE, 24'd7, '1, '0));
        queue_item(make_item(CMD_CONNECT, 4'd0, 8'd0, 24'd0, '0, '0));
        queue_item(make_item(CMD_PACKET, 4'd3, 8'hFF, 24'd0, '0, '0));
        queue_item(make_item(CMD_CONNECT, 4'd0, 8'd0, 24'd0, '0, '0));
        queue_item(make_item(CMD_PACKET, 4'd1, 8'd0, 24'd0, '0, '0));
        queue_item(make_item(CMD_CONNECT, 4'd0, 8'd0, 24'd0, '0, '0));
        queue_item(make_item(CMD_PACKET, 4'd15, TYPE_IRQ, 24'd0, '0, '0));
        queue_item(make_item(CMD_CONNECT, 4'd0, 8'd0, 24'd0, '0, '0));
        queue_item(make_item(CMD_DROP, 4'd0, 8'd0, 24'd0, '0, '0));
        wait_idle();

        foreach (limits[i])
        begin
            write_limit(limits[i]);
            // A long receiver hold-off at the start of some phases backs the block up.
            if (i == 0 || i == 3)
                squeeze_asked++;
            repeat (PHASE_ITEMS) queue_item(random_item());
            wait_idle();
        end

        $display("Run covered %0d items under %0d memory limit settings, %0d status reads",
                 taken_count, limit_settings, status_reads);
        $display("Replies: %0d silent, %0d ACK (%0d with read data), %0d ERR, %0d closures",
                 kind_tally[KIND_NONE], kind_tally[KIND_ACK], read_acks,
                 kind_tally[KIND_ERR], kind_tally[KIND_CLOSED]);
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Timed out with %0d results outstanding", replies_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/smls_pkg.sv
rtl/smls_ram.sv
rtl/smls_ctrl.sv
rtl/smls_dp.sv
rtl/shared_memory_link_slave.sv
rtl/smls_checker.sv
dv/testbench.sv
